/* rtl/igbm_pkg.sv */
// ----------------------------------------------------------------------------
// igbm_pkg
// Shared widths, register indexes, control/status types and the exhaustion
// check for the indexed greedy bipartite matcher.
// ----------------------------------------------------------------------------
package igbm_pkg;

  localparam int MASK_W      = 8;
  localparam int ADJ_W       = 64;
  localparam int ADJ_BASE_W  = 6;
  localparam int INDEX_W     = 16;
  localparam int COUNT_W     = 4;
  localparam int LEVEL_W     = 3;
  localparam int DEF_MAX_SIZE = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ADJ_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ADJACENCY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SIZE = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] ACTIVE_SIZE_RST = COUNT_W'(8);

  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = INDEX_W / MOD_BITS;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  typedef struct packed {
    logic load;
    logic row_start;
    logic row_next;
    logic mod_step;
    logic pick;
    logic out_load;
  } igbm_cmd_t;

  typedef struct packed {
    logic exh;
    logic size_zero;
    logic row_free;
    logic row_last;
    logic mod_last;
  } igbm_stat_t;

  function automatic logic is_exhausted(input logic [INDEX_W-1:0] index,
                                        input logic [COUNT_W-1:0] fcount);
    logic hit;
    begin
      case (fcount)
        4'd0, 4'd1: hit = (index == INDEX_W'(1));
        4'd2:       hit = (index == INDEX_W'(2));
        4'd3:       hit = (index == INDEX_W'(6));
        4'd4:       hit = (index == INDEX_W'(24));
        4'd5:       hit = (index == INDEX_W'(120));
        4'd6:       hit = (index == INDEX_W'(720));
        4'd7:       hit = (index == INDEX_W'(5040));
        4'd8:       hit = (index == INDEX_W'(40320));
        default:    hit = 1'b0;
      endcase
      return hit;
    end
  endfunction

endpackage

/* rtl/indexed_greedy_bipartite_match.sv */
// ----------------------------------------------------------------------------
// indexed_greedy_bipartite_match
// One index-steered greedy matching step over a configured adjacency matrix.
// ----------------------------------------------------------------------------
// Flow: an exhausted word goes from accept straight to the output register;
//   otherwise each active row is visited, a free one through the modulo unit.
// Throughput: one word at a time, paced by the row walk and the
//   4-bit-per-cycle modulo unit. A new word is taken once the result is in
//   the output register, even while that result is still stalled.
// Reset: adjacency clears, active size becomes 8, no result is pending.
module indexed_greedy_bipartite_match #(
  parameter int MAX_SIZE = igbm_pkg::DEF_MAX_SIZE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [igbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [igbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [igbm_pkg::MASK_W-1:0]       free_rows_i,
  input  logic [igbm_pkg::MASK_W-1:0]       free_cols_i,
  input  logic [igbm_pkg::LEVEL_W-1:0]      level_i,
  input  logic [igbm_pkg::INDEX_W-1:0]      choice_index_i,
  input  logic [igbm_pkg::COUNT_W-1:0]      free_count_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [igbm_pkg::MASK_W-1:0]       rows_taken_o,
  output logic [igbm_pkg::MASK_W-1:0]       cols_taken_o,
  output logic [igbm_pkg::MASK_W-1:0]       rows_left_o,
  output logic [igbm_pkg::MASK_W-1:0]       cols_left_o,
  output logic [igbm_pkg::COUNT_W-1:0]      taken_count_o,
  output logic                              exhausted_o,
  output logic [igbm_pkg::LEVEL_W-1:0]      level_out_o
);

  igbm_pkg::igbm_cmd_t  cmd;
  igbm_pkg::igbm_stat_t stat;

  igbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  igbm_dpath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .free_rows_i    (free_rows_i),
    .free_cols_i    (free_cols_i),
    .level_i        (level_i),
    .choice_index_i (choice_index_i),
    .free_count_i   (free_count_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .rows_taken_o   (rows_taken_o),
    .cols_taken_o   (cols_taken_o),
    .rows_left_o    (rows_left_o),
    .cols_left_o    (cols_left_o),
    .taken_count_o  (taken_count_o),
    .exhausted_o    (exhausted_o),
    .level_out_o    (level_out_o)
  );

  a_exh_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && exhausted_o) |->
      (taken_count_o == '0 && rows_taken_o == '0 && cols_taken_o == '0))
    else $error("exhausted word carries matches");

  a_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((rows_taken_o & rows_left_o) == '0 && (cols_taken_o & cols_left_o) == '0))
    else $error("taken bits still marked free");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ($countones(rows_taken_o) == int'(taken_count_o) &&
       $countones(cols_taken_o) == int'(taken_count_o)))
    else $error("taken count disagrees with taken masks");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not held off after accept");

endmodule

/* rtl/igbm_ctrl.sv */
// ----------------------------------------------------------------------------
// igbm_ctrl
// Sequencer: walks the rows, runs the modulo unit for each free row, issues
// the column pick and hands the finished word to the output register.
// ----------------------------------------------------------------------------
module igbm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  igbm_pkg::igbm_stat_t  stat_i,
  output igbm_pkg::igbm_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_ROW,
    ST_MOD,
    ST_PICK,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      ST_START: begin
      end
      ST_ROW: begin
        cmd_o.row_start = stat_i.row_free;
        cmd_o.row_next  = !stat_i.row_free && !stat_i.row_last;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
      end
      ST_PICK: begin
        cmd_o.pick     = 1'b1;
        cmd_o.row_next = !stat_i.row_last;
      end
      ST_FINISH: begin
        cmd_o.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_START;
        end
        ST_START: begin
          if (stat_i.exh || stat_i.size_zero) state_q <= ST_FINISH;
          else state_q <= ST_ROW;
        end
        ST_ROW: begin
          if (stat_i.row_free) state_q <= ST_MOD;
          else if (stat_i.row_last) state_q <= ST_FINISH;
        end
        ST_MOD: begin
          if (stat_i.mod_last) state_q <= ST_PICK;
        end
        ST_PICK: begin
          if (stat_i.row_last) state_q <= ST_FINISH;
          else state_q <= ST_ROW;
        end
        ST_FINISH: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/igbm_dpath.sv */
// ----------------------------------------------------------------------------
// igbm_dpath
// Datapath: configuration registers, working masks, a modulo unit that
// retires four index bits per cycle, the column pick and the output register.
// ----------------------------------------------------------------------------
module igbm_dpath #(
  parameter int MAX_SIZE = igbm_pkg::DEF_MAX_SIZE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [igbm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [igbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [igbm_pkg::MASK_W-1:0]       free_rows_i,
  input  logic [igbm_pkg::MASK_W-1:0]       free_cols_i,
  input  logic [igbm_pkg::LEVEL_W-1:0]      level_i,
  input  logic [igbm_pkg::INDEX_W-1:0]      choice_index_i,
  input  logic [igbm_pkg::COUNT_W-1:0]      free_count_i,
  input  igbm_pkg::igbm_cmd_t               cmd_i,
  output igbm_pkg::igbm_stat_t              stat_o,
  output logic [igbm_pkg::MASK_W-1:0]       rows_taken_o,
  output logic [igbm_pkg::MASK_W-1:0]       cols_taken_o,
  output logic [igbm_pkg::MASK_W-1:0]       rows_left_o,
  output logic [igbm_pkg::MASK_W-1:0]       cols_left_o,
  output logic [igbm_pkg::COUNT_W-1:0]      taken_count_o,
  output logic                              exhausted_o,
  output logic [igbm_pkg::LEVEL_W-1:0]      level_out_o
);

  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  logic [igbm_pkg::ADJ_W-1:0]    adj_q;
  logic [igbm_pkg::COUNT_W-1:0]  size_cfg_q;

  logic [igbm_pkg::MASK_W-1:0]   rows_q, cols_q, rtaken_q, ctaken_q;
  logic [igbm_pkg::COUNT_W-1:0]  taken_q, fcount_q, div_q, rem_q;
  logic [igbm_pkg::INDEX_W-1:0]  index_q, dvd_q;
  logic [igbm_pkg::LEVEL_W-1:0]  level_q;
  logic                          exh_q;
  logic [IDX_W-1:0]              row_q;
  logic [igbm_pkg::STEP_W-1:0]   step_q;

  logic [igbm_pkg::MASK_W-1:0]   out_rtaken_q, out_ctaken_q, out_rows_q, out_cols_q;
  logic [igbm_pkg::COUNT_W-1:0]  out_taken_q;
  logic                          out_exh_q;
  logic [igbm_pkg::LEVEL_W-1:0]  out_level_q;

  logic [igbm_pkg::COUNT_W-1:0]    size;
  logic [igbm_pkg::COUNT_W-1:0]    div_d;
  logic [igbm_pkg::COUNT_W-1:0]    rem_d;
  logic [igbm_pkg::COUNT_W-1:0]    skip;
  logic [igbm_pkg::ADJ_BASE_W-1:0] adj_base;
  logic [igbm_pkg::MASK_W-1:0]     adj_row, act_mask, cand, sel;
  logic [igbm_pkg::COUNT_W-1:0]    cnt;
  logic                            found;
  logic [igbm_pkg::COUNT_W:0]      part;

  assign size = (size_cfg_q > igbm_pkg::COUNT_W'(MAX_SIZE)) ?
                igbm_pkg::COUNT_W'(MAX_SIZE) : size_cfg_q;

  assign div_d = (fcount_q >= taken_q) ? (fcount_q - taken_q) : (taken_q - fcount_q);
  assign skip  = (div_q == '0) ? '0 : rem_q;

  assign adj_base = igbm_pkg::ADJ_BASE_W'(row_q) << 3;
  assign adj_row  = adj_q[adj_base +: igbm_pkg::MASK_W];

  always_comb begin
    for (int c = 0; c < igbm_pkg::MASK_W; c++) begin
      act_mask[c] = (igbm_pkg::COUNT_W'(c) < size);
    end
  end

  assign cand = cols_q & adj_row & act_mask;

  always_comb begin
    cnt   = '0;
    found = 1'b0;
    sel   = '0;
    for (int c = 0; c < igbm_pkg::MASK_W; c++) begin
      if (cand[c]) begin
        if (!found && (cnt == skip)) begin
          found  = 1'b1;
          sel[c] = 1'b1;
        end
        cnt = cnt + 1'b1;
      end
    end
  end

  always_comb begin
    part  = '0;
    rem_d = rem_q;
    for (int b = 0; b < igbm_pkg::MOD_BITS; b++) begin
      part = {rem_d, dvd_q[igbm_pkg::INDEX_W-1-b]};
      if (part >= {1'b0, div_q}) part = part - {1'b0, div_q};
      rem_d = part[igbm_pkg::COUNT_W-1:0];
    end
  end

  assign stat_o.exh       = exh_q;
  assign stat_o.size_zero = (size == '0);
  assign stat_o.row_free  = rows_q[row_q];
  assign stat_o.row_last  = (igbm_pkg::COUNT_W'(row_q) == (size - 1'b1));
  assign stat_o.mod_last  = (step_q == igbm_pkg::STEP_W'(igbm_pkg::MOD_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q      <= '0;
      size_cfg_q <= igbm_pkg::ACTIVE_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        igbm_pkg::CFG_ADJACENCY:   adj_q      <= cfg_data_i;
        igbm_pkg::CFG_ACTIVE_SIZE: size_cfg_q <= cfg_data_i[igbm_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rows_q   <= free_rows_i;
      cols_q   <= free_cols_i;
      level_q  <= level_i;
      index_q  <= choice_index_i;
      fcount_q <= free_count_i;
      exh_q    <= igbm_pkg::is_exhausted(choice_index_i, free_count_i);
      rtaken_q <= '0;
      ctaken_q <= '0;
      taken_q  <= '0;
      row_q    <= '0;
    end
    if (cmd_i.row_start) begin
      dvd_q  <= index_q;
      rem_q  <= '0;
      div_q  <= div_d;
      step_q <= '0;
    end
    if (cmd_i.mod_step) begin
      dvd_q  <= dvd_q << igbm_pkg::MOD_BITS;
      rem_q  <= rem_d;
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.pick && found) begin
      rows_q            <= rows_q & ~(igbm_pkg::MASK_W'(1) << row_q);
      rtaken_q          <= rtaken_q | (igbm_pkg::MASK_W'(1) << row_q);
      cols_q            <= cols_q & ~sel;
      ctaken_q          <= ctaken_q | sel;
      taken_q           <= taken_q + 1'b1;
    end
    if (cmd_i.row_next) begin
      row_q <= row_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_rtaken_q <= rtaken_q;
      out_ctaken_q <= ctaken_q;
      out_rows_q   <= rows_q;
      out_cols_q   <= cols_q;
      out_taken_q  <= taken_q;
      out_exh_q    <= exh_q;
      out_level_q  <= level_q;
    end
  end

  assign rows_taken_o  = out_rtaken_q;
  assign cols_taken_o  = out_ctaken_q;
  assign rows_left_o   = out_rows_q;
  assign cols_left_o   = out_cols_q;
  assign taken_count_o = out_taken_q;
  assign exhausted_o   = out_exh_q;
  assign level_out_o   = out_level_q;

endmodule

/* tb/indexed_greedy_bipartite_match_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_greedy_bipartite_match_test
// Self-checking bench for the index-steered greedy matcher. A scoreboard
// class predicts each result word from its own copy of the adjacency and
// active-size registers. Directed words cover the exhaustion, divisor and
// active-size corners. Random phases then reprogram the registers while the
// block is idle, with random idling on both sides, one quiet phase, and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module indexed_greedy_bipartite_match_test;
  import igbm_pkg::*;

  localparam int MAX_SIZE        = DEF_MAX_SIZE;
  localparam int RANDOM_PHASES   = 33;
  localparam int WORDS_PER_PHASE = 50;
  localparam int QUIET_PHASE     = 6;
  localparam int HOLD_PHASE      = 12;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 60;
  localparam int MAX_PRINTED     = 50;
  localparam longint TIMEOUT_NS  = 64'd5_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = CFG_IDX_W'(3);
  localparam logic [ADJ_W-1:0]     ADJ_FULL     = {ADJ_W{1'b1}};
  localparam logic [ADJ_W-1:0]     ADJ_DIAGONAL = 64'h8040_2010_0804_0201;

  typedef struct packed {
    logic [MASK_W-1:0]  free_rows;
    logic [MASK_W-1:0]  free_cols;
    logic [LEVEL_W-1:0] level;
    logic [INDEX_W-1:0] choice_index;
    logic [COUNT_W-1:0] free_count;
  } match_req_t;

  typedef struct packed {
    logic [MASK_W-1:0]  rows_taken;
    logic [MASK_W-1:0]  cols_taken;
    logic [MASK_W-1:0]  rows_left;
    logic [MASK_W-1:0]  cols_left;
    logic [COUNT_W-1:0] taken_count;
    logic               exhausted;
    logic [LEVEL_W-1:0] level_out;
  } match_rsp_t;

  class match_scoreboard;
    logic [ADJ_W-1:0]   adjacency;
    logic [COUNT_W-1:0] active_size;
    match_rsp_t         expected_words[$];
    int                 fails;

    function new();
      adjacency   = '0;
      active_size = ACTIVE_SIZE_RST;
      fails       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ADJACENCY) begin
        adjacency = data;
      end else if (idx == CFG_ACTIVE_SIZE) begin
        active_size = data[COUNT_W-1:0];
      end
    endfunction

    function match_rsp_t greedy_match(match_req_t w);
      match_rsp_t  res;
      logic [63:0] fact;
      int          size;
      int          fcount;
      int          index;
      int          taken;
      int          div;
      int          skip;
      bit          picked;
      size   = (active_size > MAX_SIZE) ? MAX_SIZE : int'(active_size);
      fcount = int'(w.free_count);
      index  = int'(w.choice_index);
      fact   = 64'd1;
      for (int i = 2; i <= fcount; i++) fact = fact * 64'(i);
      res.rows_taken  = '0;
      res.cols_taken  = '0;
      res.rows_left   = w.free_rows;
      res.cols_left   = w.free_cols;
      res.taken_count = '0;
      res.exhausted   = 1'b0;
      res.level_out   = w.level;
      if (64'(w.choice_index) == fact) begin
        res.exhausted = 1'b1;
        return res;
      end
      taken = 0;
      for (int r = 0; r < size; r++) begin
        if (res.rows_left[r]) begin
          div    = (fcount >= taken) ? fcount - taken : taken - fcount;
          skip   = (div == 0) ? 0 : index % div;
          picked = 1'b0;
          for (int c = 0; c < size; c++) begin
            if (!picked && res.cols_left[c] && adjacency[r*MASK_W+c]) begin
              if (skip > 0) begin
                skip--;
              end else begin
                res.rows_left[r]  = 1'b0;
                res.cols_left[c]  = 1'b0;
                res.rows_taken[r] = 1'b1;
                res.cols_taken[c] = 1'b1;
                taken++;
                picked = 1'b1;
              end
            end
          end
        end
      end
      res.taken_count = COUNT_W'(taken);
      return res;
    endfunction

    function void note_input(match_req_t w);
      expected_words.push_back(greedy_match(w));
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction

    task report(string msg);
      if (fails < MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
      fails++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(match_rsp_t got);
      match_rsp_t want;
      if (expected_words.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      want = expected_words.pop_front();
      compare_field("rows_taken",  got.rows_taken,  want.rows_taken);
      compare_field("cols_taken",  got.cols_taken,  want.cols_taken);
      compare_field("rows_left",   got.rows_left,   want.rows_left);
      compare_field("cols_left",   got.cols_left,   want.cols_left);
      compare_field("taken_count", got.taken_count, want.taken_count);
      compare_field("exhausted",   got.exhausted,   want.exhausted);
      compare_field("level_out",   got.level_out,   want.level_out);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [MASK_W-1:0]     free_rows_i;
  logic [MASK_W-1:0]     free_cols_i;
  logic [LEVEL_W-1:0]    level_i;
  logic [INDEX_W-1:0]    choice_index_i;
  logic [COUNT_W-1:0]    free_count_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [MASK_W-1:0]     rows_taken_o;
  logic [MASK_W-1:0]     cols_taken_o;
  logic [MASK_W-1:0]     rows_left_o;
  logic [MASK_W-1:0]     cols_left_o;
  logic [COUNT_W-1:0]    taken_count_o;
  logic                  exhausted_o;
  logic [LEVEL_W-1:0]    level_out_o;

  match_scoreboard sb;
  bit              calm;
  int              hold_requests;

  indexed_greedy_bipartite_match #(
    .MAX_SIZE(MAX_SIZE)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .free_rows_i   (free_rows_i),
    .free_cols_i   (free_cols_i),
    .level_i       (level_i),
    .choice_index_i(choice_index_i),
    .free_count_i  (free_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rows_taken_o  (rows_taken_o),
    .cols_taken_o  (cols_taken_o),
    .rows_left_o   (rows_left_o),
    .cols_left_o   (cols_left_o),
    .taken_count_o (taken_count_o),
    .exhausted_o   (exhausted_o),
    .level_out_o   (level_out_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("** indexed_greedy_bipartite_match: FAILED **");
    $finish;
  end

  initial begin
    int hold_left;
    int holds_seen;
    hold_left   = 0;
    holds_seen  = 0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{rows_taken_o, cols_taken_o, rows_left_o, cols_left_o,
                        taken_count_o, exhausted_o, level_out_o});
    end
  end

  function automatic match_req_t req(logic [7:0] rows, logic [7:0] cols, logic [2:0] lvl,
                                     logic [15:0] index, logic [3:0] fcount);
    return '{rows, cols, lvl, index, fcount};
  endfunction

  function automatic match_req_t random_word(int size);
    match_req_t  w;
    logic [7:0]  active;
    logic [63:0] fact;
    int          fcount;
    active = (size >= MAX_SIZE) ? 8'hFF : 8'((9'd1 << size) - 9'd1);
    w      = match_req_t'({$urandom, $urandom});
    if ($urandom_range(99) < 30) return w;
    w.free_rows = 8'($urandom) & active;
    w.free_cols = ($urandom_range(2) == 0) ? active : 8'($urandom) & active;
    if ($urandom_range(7) == 0) w.free_rows |= 8'($urandom);
    if ($urandom_range(7) == 0) w.free_cols |= 8'($urandom);
    fcount = $countones(w.free_rows & active);
    fact   = 64'd1;
    for (int i = 2; i <= fcount; i++) fact = fact * 64'(i);
    w.free_count = COUNT_W'(fcount);
    if ($urandom_range(9) != 0) w.choice_index = 16'($urandom_range(int'(fact)));
    return w;
  endfunction

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task configure(logic [ADJ_W-1:0] adj, logic [CFG_DATA_W-1:0] size_data, bit junk);
    if (junk) write_reg(($urandom_range(1) == 0) ? CFG_UNUSED_2 : CFG_UNUSED_3,
                        {$urandom, $urandom});
    write_reg(CFG_ADJACENCY, adj);
    write_reg(CFG_ACTIVE_SIZE, size_data);
    cfg_we_i <= 1'b0;
  endtask

  task send_word(match_req_t w);
    if (!calm) begin
      while ($urandom_range(99) < 30) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    free_rows_i    <= w.free_rows;
    free_cols_i    <= w.free_cols;
    level_i        <= w.level;
    choice_index_i <= w.choice_index;
    free_count_i   <= w.free_count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(w);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [ADJ_W-1:0]      adj;
    logic [CFG_DATA_W-1:0] size_data;
    int                    size;
    sb             = new();
    calm           = 1'b0;
    hold_requests  = 0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    free_rows_i    = '0;
    free_cols_i    = '0;
    level_i        = '0;
    choice_index_i = '0;
    free_count_i   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(req(8'hFF, 8'hFF, 3'd0, 16'd0, 4'd8));
    drain();
    configure(ADJ_FULL, 64'(MAX_SIZE), 1'b1);
    send_word(req(8'hFF, 8'hFF, 3'd7, 16'd0, 4'd8));
    send_word(req(8'hFF, 8'hFF, 3'd3, 16'd40320, 4'd8));
    send_word(req(8'hFF, 8'hFF, 3'd1, 16'd1, 4'd0));
    send_word(req(8'hFF, 8'hFF, 3'd2, 16'd1, 4'd1));
    send_word(req(8'hFF, 8'hFF, 3'd0, 16'd0, 4'd0));
    send_word(req(8'hFF, 8'hFF, 3'd5, 16'hFFFF, 4'd15));
    send_word(req(8'hFF, 8'hFF, 3'd6, 16'hFFFF, 4'd8));
    send_word(req(8'hFF, 8'hFF, 3'd4, 16'd5, 4'd3));
    send_word(req(8'h00, 8'h00, 3'd0, 16'd0, 4'd0));
    send_word(req(8'hFF, 8'h00, 3'd1, 16'd3, 4'd8));
    send_word(req(8'h00, 8'hFF, 3'd2, 16'd3, 4'd8));
    send_word(req(8'h55, 8'hAA, 3'd3, 16'd7, 4'd4));
    drain();
    configure(ADJ_FULL, 64'd0, 1'b0);
    send_word(req(8'hFF, 8'hFF, 3'd0, 16'd2, 4'd8));
    drain();
    configure(ADJ_DIAGONAL, 64'd15, 1'b0);
    send_word(req(8'hFF, 8'hFF, 3'd1, 16'd3, 4'd8));
    send_word(req(8'hFF, 8'hFF, 3'd2, 16'd0, 4'd8));
    drain();
    configure(ADJ_FULL, 64'd1, 1'b0);
    send_word(req(8'hFF, 8'hFF, 3'd3, 16'd0, 4'd1));
    drain();
    configure(ADJ_FULL, 64'd4, 1'b0);
    send_word(req(8'hFF, 8'hFF, 3'd2, 16'd1, 4'd4));
    send_word(req(8'hF0, 8'h0F, 3'd6, 16'd2, 4'd4));
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(3))
        0:       adj = ADJ_FULL;
        1:       adj = {$urandom, $urandom};
        2:       adj = {$urandom, $urandom} & {$urandom, $urandom};
        default: adj = {$urandom, $urandom} | {$urandom, $urandom};
      endcase
      case ($urandom_range(9))
        0:       size = 0;
        1:       size = $urandom_range(MAX_SIZE + 1, 15);
        default: size = $urandom_range(1, MAX_SIZE);
      endcase
      size_data = {$urandom, $urandom};
      size_data[COUNT_W-1:0] = COUNT_W'(size);
      configure(adj, size_data, $urandom_range(3) == 0);
      calm = (phase == QUIET_PHASE);
      if (phase == HOLD_PHASE) hold_requests++;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(random_word((size > MAX_SIZE) ? MAX_SIZE : size));
      end
      drain();
    end

    calm = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.fails == 0 && sb.outstanding() == 0) begin
      $display("** indexed_greedy_bipartite_match: PASSED **");
    end else begin
      $display("** indexed_greedy_bipartite_match: FAILED **");
    end
    $finish;
  end

endmodule
